// File: rtl/lprf_pkg.sv
package lprf_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 12;
  localparam int THR_W      = 13;
  localparam int FREE_W     = 13;
  localparam int STATUS_W   = 2;
  localparam int OPCODE_W   = 2;

  localparam logic [THR_W-1:0] THR_RESET = 13'd1229;

  typedef enum logic [OPCODE_W-1:0] {
    OP_BEGIN = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NO_OPEN = 2'd3
  } status_e;

endpackage

// File: rtl/lprf_ram.sv
module lprf_ram import lprf_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// File: rtl/length_prefixed_record_ring_fifo.sv
// Byte ring of CAPACITY_BYTES holding variable-length records, each stored as a
// HEADER_BYTES little-endian length followed by its data. Items are commands
// taken when start is high and busy low; every command gives exactly one
// result, shown for one cycle with valid_o high, and the receiver cannot stall
// it. Timing from accept to result: write byte, clear, rejected begin and empty
// read give their result in the next cycle and leave busy low, so they run
// one per cycle. A begin writes the header one byte per cycle through the
// single memory port and shows its result in the cycle after the last header
// byte. A read inside an open record fetches its byte through the registered
// memory read and then shows it. A read that opens a new record fetches the
// header bytes one per cycle, clamps the length in a further step and then
// fetches the first data byte; a zero-length record ends at the clamp. The ring
// needs no clearing pass after reset or clear; only committed bytes are read.
// The user must write space_threshold_i only while the block is idle; the
// block itself does not enforce it.
module length_prefixed_record_ring_fifo import lprf_pkg::*; #(
  parameter int CAPACITY_BYTES = 4096,
  parameter int HEADER_BYTES   = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [LEN_W-1:0]    record_length_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  input  logic                space_threshold_we_i,
  input  logic [THR_W-1:0]    space_threshold_i,
  output logic                valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [BYTE_W-1:0]   read_byte_o,
  output logic [LEN_W-1:0]    read_length_o,
  output logic                last_byte_o,
  output logic [FREE_W-1:0]   free_space_o,
  output logic                space_ok_o
);

  // pointer width, byte count width, compare width, header counter width
  localparam int AW   = $clog2(CAPACITY_BYTES);
  localparam int CW   = $clog2(CAPACITY_BYTES + 1);
  localparam int CMPW = (CW > THR_W ? CW : THR_W) + 1;
  localparam int HCW  = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

  localparam logic [AW-1:0]   PTR_LAST = AW'(CAPACITY_BYTES - 1);
  localparam logic [CW-1:0]   CAP_CW   = CW'(CAPACITY_BYTES);
  localparam logic [CW-1:0]   HDR_CW   = CW'(HEADER_BYTES);
  localparam logic [HCW-1:0]  HCNT_END = HCW'(HEADER_BYTES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR_WR,
    S_RD_HDR,
    S_RD_EVAL,
    S_RD_DATA
  } state_e;

  state_e state_q, state_d;

  // ring bookkeeping
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]    committed_q, committed_d;
  logic [CW-1:0]    reserved_q, reserved_d;
  logic [LEN_W-1:0] wrem_q, wrem_d;
  logic             write_open_q, write_open_d;
  logic [LEN_W-1:0] rrem_q, rrem_d;
  logic             read_open_q, read_open_d;
  logic [LEN_W-1:0] held_q, held_d;
  logic [THR_W-1:0] thr_q;

  // sequencer working registers
  logic [HCW-1:0]   cnt_q, cnt_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] hdr_q, hdr_d;

  // result beat
  logic                valid_q, valid_d;
  status_e             status_q, status_d;
  logic [BYTE_W-1:0]   rbyte_q, rbyte_d;
  logic [LEN_W-1:0]    rlen_q, rlen_d;
  logic                last_q, last_d;

  // memory port
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  logic [CW-1:0]    used, free;
  logic [AW-1:0]    wp_next, rp_next;
  logic [CMPW-1:0]  total, rel;
  logic [CW-1:0]    room;
  logic [LEN_W-1:0] hcl;
  logic [BYTE_W-1:0] hdr_byte;
  logic [31:0]      free_ext;

  lprf_ram #(
    .DEPTH (CAPACITY_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // committed plus reserved never exceeds capacity, so no clamp is needed
  assign used    = committed_q + reserved_q;
  assign free    = CAP_CW - used;
  assign wp_next = (wp_q == PTR_LAST) ? '0 : wp_q + AW'(1);
  assign rp_next = (rp_q == PTR_LAST) ? '0 : rp_q + AW'(1);
  assign total   = CMPW'(HEADER_BYTES) + CMPW'(record_length_i);
  assign rel     = CMPW'(HEADER_BYTES) + CMPW'(held_q);

  // header length clamped to the committed bytes behind the header
  assign room = committed_q - HDR_CW;
  assign hcl  = (CMPW'(hdr_q) > CMPW'(room)) ? LEN_W'(room) : hdr_q;

  // little-endian header byte, only the low two bytes carry length bits
  always_comb begin
    hdr_byte = '0;
    if (cnt_q == HCW'(0)) begin
      hdr_byte = len_q[7:0];
    end else if (cnt_q == HCW'(1)) begin
      hdr_byte = {4'b0, len_q[11:8]};
    end
  end

  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    rp_d         = rp_q;
    committed_d  = committed_q;
    reserved_d   = reserved_q;
    wrem_d       = wrem_q;
    write_open_d = write_open_q;
    rrem_d       = rrem_q;
    read_open_d  = read_open_q;
    held_d       = held_q;
    cnt_d        = cnt_q;
    len_d        = len_q;
    hdr_d        = hdr_q;
    valid_d      = 1'b0;
    status_d     = ST_OK;
    rbyte_d      = '0;
    rlen_d       = '0;
    last_d       = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = rp_q;
    mem_wdata    = data_byte_i;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (op_e'(opcode_i))
            OP_BEGIN: begin
              if (write_open_q || (total > CMPW'(free))) begin
                status_d = ST_REJECT;
                valid_d  = 1'b1;
              end else begin
                len_d   = record_length_i;
                cnt_d   = '0;
                state_d = S_HDR_WR;
              end
            end
            OP_WRITE: begin
              valid_d = 1'b1;
              if (!write_open_q) begin
                status_d = ST_NO_OPEN;
              end else begin
                mem_we   = 1'b1;
                mem_addr = wp_q;
                wp_d     = wp_next;
                wrem_d   = wrem_q - LEN_W'(1);
                if (wrem_q == LEN_W'(1)) begin
                  committed_d  = committed_q + reserved_q;
                  reserved_d   = '0;
                  write_open_d = 1'b0;
                end
              end
            end
            OP_READ: begin
              if (read_open_q) begin
                rp_d    = rp_next;
                state_d = S_RD_DATA;
              end else if (CMPW'(committed_q) < CMPW'(HEADER_BYTES)) begin
                status_d = ST_EMPTY;
                valid_d  = 1'b1;
              end else begin
                rp_d    = rp_next;
                cnt_d   = '0;
                hdr_d   = '0;
                state_d = S_RD_HDR;
              end
            end
            OP_CLEAR: begin
              wp_d         = '0;
              rp_d         = '0;
              committed_d  = '0;
              reserved_d   = '0;
              wrem_d       = '0;
              write_open_d = 1'b0;
              rrem_d       = '0;
              read_open_d  = 1'b0;
              held_d       = '0;
              valid_d      = 1'b1;
            end
          endcase
        end
      end

      S_HDR_WR: begin
        mem_we    = 1'b1;
        mem_addr  = wp_q;
        mem_wdata = hdr_byte;
        wp_d      = wp_next;
        cnt_d     = cnt_q + HCW'(1);
        if (cnt_q == HCNT_END) begin
          reserved_d   = HDR_CW + CW'(len_q);
          wrem_d       = len_q;
          write_open_d = 1'b1;
          // empty record commits with its header
          if (len_q == '0) begin
            committed_d  = committed_q + HDR_CW;
            reserved_d   = '0;
            write_open_d = 1'b0;
          end
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_RD_HDR: begin
        // data of the byte issued last cycle
        if (cnt_q == HCW'(0)) begin
          hdr_d[7:0] = mem_rdata;
        end else if (cnt_q == HCW'(1)) begin
          hdr_d[11:8] = mem_rdata[3:0];
        end
        if (cnt_q == HCNT_END) begin
          state_d = S_RD_EVAL;
        end else begin
          rp_d  = rp_next;
          cnt_d = cnt_q + HCW'(1);
        end
      end

      S_RD_EVAL: begin
        if (hcl == '0) begin
          committed_d = committed_q - HDR_CW;
          held_d      = '0;
          rrem_d      = '0;
          last_d      = 1'b1;
          valid_d     = 1'b1;
          state_d     = S_IDLE;
        end else begin
          held_d      = hcl;
          rrem_d      = hcl;
          read_open_d = 1'b1;
          rp_d        = rp_next;
          state_d     = S_RD_DATA;
        end
      end

      S_RD_DATA: begin
        rbyte_d = mem_rdata;
        rlen_d  = held_q;
        rrem_d  = rrem_q - LEN_W'(1);
        if (rrem_q == LEN_W'(1)) begin
          // release header and data of the finished record
          if (rel > CMPW'(committed_q)) begin
            committed_d = '0;
          end else begin
            committed_d = committed_q - CW'(rel);
          end
          read_open_d = 1'b0;
          last_d      = 1'b1;
        end
        valid_d = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      wp_q         <= '0;
      rp_q         <= '0;
      committed_q  <= '0;
      reserved_q   <= '0;
      wrem_q       <= '0;
      write_open_q <= 1'b0;
      rrem_q       <= '0;
      read_open_q  <= 1'b0;
      held_q       <= '0;
      thr_q        <= THR_RESET;
      valid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      wp_q         <= wp_d;
      rp_q         <= rp_d;
      committed_q  <= committed_d;
      reserved_q   <= reserved_d;
      wrem_q       <= wrem_d;
      write_open_q <= write_open_d;
      rrem_q       <= rrem_d;
      read_open_q  <= read_open_d;
      held_q       <= held_d;
      valid_q      <= valid_d;
      if (space_threshold_we_i) begin
        thr_q <= space_threshold_i;
      end
    end
  end

  // payload of the sequencer and result beat
  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    len_q    <= len_d;
    hdr_q    <= hdr_d;
    status_q <= status_d;
    rbyte_q  <= rbyte_d;
    rlen_q   <= rlen_d;
    last_q   <= last_d;
  end

  // state already holds the post-command values while the beat is shown
  assign free_ext = 32'(free);

  assign busy          = (state_q != S_IDLE);
  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign read_byte_o   = rbyte_q;
  assign read_length_o = rlen_q;
  assign last_byte_o   = last_q;
  assign free_space_o  = free_ext[FREE_W-1:0];
  assign space_ok_o    = (CMPW'(free) >= CMPW'(thr_q));

`ifndef SYNTHESIS
  a_space_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CMPW'(committed_q) + CMPW'(reserved_q)) <= CMPW'(CAPACITY_BYTES))
    else $error("committed plus reserved exceeds capacity");

  a_write_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_open_q |-> (wrem_q != '0))
    else $error("open record with nothing left to write");

  a_reserve_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !write_open_q |-> (reserved_q == '0))
    else $error("space reserved without an open record");

  a_read_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_open_q |-> ((rrem_q != '0) && (rrem_q <= held_q)))
    else $error("read remaining out of range");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || valid_o))
    else $error("accepted command neither busy nor done");
`endif

endmodule
